### design/scaled_matrix_vector_multiply_add_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scaled matrix-vector multiply-add block
// Clocked assertions with a synchronous active-low reset as disable.
// ----------------------------------------------------------------------------
`ifndef SCALED_MATRIX_VECTOR_MULTIPLY_ADD_DEFINES_SVH
`define SCALED_MATRIX_VECTOR_MULTIPLY_ADD_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define SMVMA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication: cons must hold in the cycle that ante holds.
`define SMVMA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### design/smvma_pkg.sv
// ----------------------------------------------------------------------------
// smvma_pkg
// Widths, codes, reset values and inter-module types of the scaled
// matrix-vector multiply-add block.
// ----------------------------------------------------------------------------
package smvma_pkg;

    localparam int unsigned MAX_COLUMNS_DEF = 64;
    localparam int unsigned MAX_ROWS_DEF    = 4096;

    localparam int unsigned VAL_W      = 32;
    localparam int unsigned COL_W      = 6;
    localparam int unsigned ROW_IDX_W  = 12;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned COL_CNT_W  = 7;
    localparam int unsigned ROW_CNT_W  = 13;
    localparam int unsigned FRAC_W     = 24;
    localparam int unsigned ACC_W      = 49;

    // Output queue: one slot for every result owed downstream
    localparam int unsigned OUT_DEPTH = 8;
    localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);
    localparam int unsigned PEND_W    = $clog2(OUT_DEPTH + 1);

    typedef enum logic [0:0] {
        OP_X_WRITE = 1'b0,
        OP_MATRIX  = 1'b1
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 8'd3;

    localparam logic signed [VAL_W-1:0] GAIN_ONE      = 32'sh0100_0000;
    localparam logic [COL_CNT_W-1:0]    COL_CNT_RESET = 7'd64;
    localparam logic [ROW_CNT_W-1:0]    ROW_CNT_RESET = 13'd1;

    localparam logic signed [VAL_W-1:0] INT32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] INT32_MIN = 32'sh8000_0000;
    localparam logic signed [ACC_W-1:0] ACC_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

    // Finished row sum handed from the accumulator to the scaler
    typedef struct packed {
        logic                    valid;
        logic signed [ACC_W-1:0] acc;
        logic signed [VAL_W-1:0] y;
        logic [ROW_IDX_W-1:0]    row;
        logic                    last_row;
    } t_row_done;

    typedef struct packed {
        logic [ROW_IDX_W-1:0]    row_index;
        logic signed [VAL_W-1:0] result_value;
        logic                    last_row;
        logic                    saturated;
    } t_result;

    typedef struct packed {
        logic [PEND_W-1:0] pending;
        logic [PEND_W-1:0] count;
    } t_oq_status;

endpackage

### design/smvma_if.sv
// ----------------------------------------------------------------------------
// smvma channel interfaces
// Item, result and configuration channels, valid/ready with payload.
// ----------------------------------------------------------------------------
interface smvma_item_if import smvma_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [COL_W-1:0]        column_index;
    logic signed [VAL_W-1:0] element_value;
    logic signed [VAL_W-1:0] y_value;

    modport source (output valid, opcode, column_index, element_value, y_value,
                    input ready);
    modport sink   (input valid, opcode, column_index, element_value, y_value,
                    output ready);
endinterface

interface smvma_result_if import smvma_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ROW_IDX_W-1:0]    row_index;
    logic signed [VAL_W-1:0] result_value;
    logic                    last_row;
    logic                    saturated;

    modport source (output valid, row_index, result_value, last_row, saturated,
                    input ready);
    modport sink   (input valid, row_index, result_value, last_row, saturated,
                    output ready);
endinterface

interface smvma_cfg_if import smvma_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/smvma_ram.sv
// ----------------------------------------------------------------------------
// smvma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module smvma_ram import smvma_pkg::*; #(
    parameter int unsigned WIDTH = VAL_W,
    parameter int unsigned DEPTH = MAX_COLUMNS_DEF,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### design/smvma_acc.sv
// ----------------------------------------------------------------------------
// smvma_acc
// Multiplies each matrix beat by its x entry, floors to Q.24 and adds it into
// the saturating row accumulator; hands the finished row on and counts rows.
// ----------------------------------------------------------------------------
module smvma_acc import smvma_pkg::*; #(
    parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
    localparam int unsigned RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_mat_go,
    input  logic                    i_last_col,
    input  logic signed [VAL_W-1:0] i_elem,
    input  logic signed [VAL_W-1:0] i_y,
    input  logic [VAL_W-1:0]        i_xdata,
    input  logic [ROW_CNT_W-1:0]    i_row_count,
    output t_row_done               o_done
);

    localparam int unsigned PROD_W = 2 * VAL_W;

    logic                     r_s1_valid;
    logic                     r_s1_last;
    logic signed [VAL_W-1:0]  r_s1_elem;
    logic signed [VAL_W-1:0]  r_s1_y;

    logic                     r_s2_valid;
    logic                     r_s2_last;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic signed [VAL_W-1:0]  r_s2_y;

    logic signed [ACC_W-1:0]  r_acc;
    logic [RW-1:0]            r_row;

    logic                     r_done_valid;
    logic signed [ACC_W-1:0]  r_done_acc;
    logic signed [VAL_W-1:0]  r_done_y;
    logic [ROW_IDX_W-1:0]     r_done_row;
    logic                     r_done_last;

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_term;
    logic signed [ACC_W:0]    w_sum;
    logic signed [ACC_W-1:0]  w_acc_new;
    logic [31:0]              w_rows_eff;
    logic                     w_row_last;

    // x entry arrives in the cycle after the accept edge, together with stage 1
    assign w_prod = r_s1_elem * $signed(i_xdata);

    assign w_term = r_s2_prod >>> FRAC_W;
    assign w_sum  = (ACC_W+1)'(r_acc) + (ACC_W+1)'(w_term);

    always_comb begin
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_acc_new = w_sum[ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            w_acc_new = w_sum[ACC_W-1:0];
        end
    end

    always_comb begin
        if (i_row_count == '0) begin
            w_rows_eff = 32'd1;
        end else if (32'(i_row_count) > 32'(MAX_ROWS)) begin
            w_rows_eff = 32'(MAX_ROWS);
        end else begin
            w_rows_eff = 32'(i_row_count);
        end
    end

    // a counter left past the end by a smaller row count still ends the vector
    assign w_row_last = 32'(r_row) >= (w_rows_eff - 32'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_done_valid <= 1'b0;
            r_acc        <= '0;
            r_row        <= '0;
        end else begin
            r_s1_valid   <= i_mat_go;
            r_s2_valid   <= r_s1_valid;
            r_done_valid <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                r_acc <= r_s2_last ? '0 : w_acc_new;
                if (r_s2_last) begin
                    r_row <= w_row_last ? '0 : RW'(r_row + 1'b1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last   <= i_last_col;
        r_s1_elem   <= i_elem;
        r_s1_y      <= i_y;
        r_s2_last   <= r_s1_last;
        r_s2_prod   <= w_prod;
        r_s2_y      <= r_s1_y;
        r_done_acc  <= w_acc_new;
        r_done_y    <= r_s2_y;
        r_done_row  <= ROW_IDX_W'(r_row);
        r_done_last <= w_row_last;
    end

    assign o_done = '{valid:    r_done_valid,
                      acc:      r_done_acc,
                      y:        r_done_y,
                      row:      r_done_row,
                      last_row: r_done_last};

endmodule

### design/smvma_scale.sv
// ----------------------------------------------------------------------------
// smvma_scale
// Forms floor((alpha*sum + beta*y) / 2^24) exactly by splitting the sum at
// the binary point, then clips to 32 bits and flags the clip.
// ----------------------------------------------------------------------------
module smvma_scale import smvma_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_row_done               i_done,
    input  logic signed [VAL_W-1:0] i_alpha,
    input  logic signed [VAL_W-1:0] i_beta,
    output logic                    o_valid,
    output t_result                 o_res
);

    localparam int unsigned SH_W  = ACC_W - FRAC_W;
    localparam int unsigned HI_W  = VAL_W + SH_W;
    localparam int unsigned LO_W  = VAL_W + FRAC_W + 1;
    localparam int unsigned BY_W  = 2 * VAL_W;
    localparam int unsigned TOT_W = HI_W + 1;
    localparam logic signed [TOT_W-1:0] TOT_MAX = TOT_W'(INT32_MAX);
    localparam logic signed [TOT_W-1:0] TOT_MIN = TOT_W'(INT32_MIN);

    logic                    r_a_valid;
    logic signed [HI_W-1:0]  r_a_hi;
    logic signed [LO_W-1:0]  r_a_lo;
    logic signed [BY_W-1:0]  r_a_by;
    logic [ROW_IDX_W-1:0]    r_a_row;
    logic                    r_a_last;

    logic                    r_b_valid;
    logic signed [HI_W-1:0]  r_b_hi;
    logic signed [BY_W-1:0]  r_b_low;
    logic [ROW_IDX_W-1:0]    r_b_row;
    logic                    r_b_last;

    logic                    r_res_valid;
    t_result                 r_res;

    logic signed [SH_W-1:0]  w_sh;
    logic signed [FRAC_W:0]  w_sl;
    logic signed [BY_W-1:0]  w_lowf;
    logic signed [TOT_W-1:0] w_total;

    // integer part floored, fraction kept as a positive 24-bit value
    assign w_sh = i_done.acc[ACC_W-1:FRAC_W];
    assign w_sl = {1'b0, i_done.acc[FRAC_W-1:0]};

    assign w_lowf  = r_b_low >>> FRAC_W;
    assign w_total = TOT_W'(r_b_hi) + TOT_W'(w_lowf);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_a_valid   <= i_done.valid;
            r_b_valid   <= r_a_valid;
            r_res_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_hi   <= i_alpha * w_sh;
        r_a_lo   <= i_alpha * w_sl;
        r_a_by   <= i_beta * i_done.y;
        r_a_row  <= i_done.row;
        r_a_last <= i_done.last_row;

        r_b_hi   <= r_a_hi;
        r_b_low  <= BY_W'(r_a_lo) + r_a_by;
        r_b_row  <= r_a_row;
        r_b_last <= r_a_last;

        r_res.row_index <= r_b_row;
        r_res.last_row  <= r_b_last;
        if (w_total > TOT_MAX) begin
            r_res.result_value <= INT32_MAX;
            r_res.saturated    <= 1'b1;
        end else if (w_total < TOT_MIN) begin
            r_res.result_value <= INT32_MIN;
            r_res.saturated    <= 1'b1;
        end else begin
            r_res.result_value <= w_total[VAL_W-1:0];
            r_res.saturated    <= 1'b0;
        end
    end

    assign o_valid = r_res_valid;
    assign o_res   = r_res;

endmodule

### design/smvma_oq.sv
// ----------------------------------------------------------------------------
// smvma_oq
// Output queue. A slot is reserved when a row-ending beat is accepted, so
// the pipeline never stalls and never overruns the queue.
// ----------------------------------------------------------------------------
module smvma_oq import smvma_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_reserve,
    input  logic                  i_push,
    input  t_result               i_data,
    output logic                  o_room,
    output t_oq_status            o_status,
    smvma_result_if.source        o_result
);

    t_result           r_q [OUT_DEPTH];
    logic [OUT_AW-1:0] r_wptr;
    logic [OUT_AW-1:0] r_rptr;
    logic [PEND_W-1:0] r_count;
    logic [PEND_W-1:0] r_pend;

    logic              w_pop;
    t_result           w_head;

    assign w_pop  = o_result.valid && o_result.ready;
    assign w_head = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
            r_pend  <= '0;
        end else begin
            r_pend  <= PEND_W'(r_pend + PEND_W'(i_reserve) - PEND_W'(w_pop));
            r_count <= PEND_W'(r_count + PEND_W'(i_push) - PEND_W'(w_pop));
            if (i_push) begin
                r_wptr <= (r_wptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : OUT_AW'(r_wptr + 1'b1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : OUT_AW'(r_rptr + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_data;
        end
    end

    assign o_room   = (r_pend != PEND_W'(OUT_DEPTH));
    assign o_status = '{pending: r_pend, count: r_count};

    assign o_result.valid        = (r_count != '0);
    assign o_result.row_index    = w_head.row_index;
    assign o_result.result_value = w_head.result_value;
    assign o_result.last_row     = w_head.last_row;
    assign o_result.saturated    = w_head.saturated;

endmodule

### design/scaled_matrix_vector_multiply_add.sv
// ----------------------------------------------------------------------------
// scaled_matrix_vector_multiply_add
// c = alpha*A*x + beta*y in signed Q8.24. x is held in a RAM, matrix beats
// stream row-major and one result leaves per row.
// ----------------------------------------------------------------------------
//  Port      Dir  Payload                                         Beat when
//  i_cfg     in   index, data (alpha, beta, column/row count)     valid & ready
//  i_item    in   opcode, column_index, element_value, y_value    valid & ready
//  o_result  out  row_index, result_value, last_row, saturated    valid & ready
//
//  One item per cycle while the output queue has room. After the x RAM read
//  at a row's last beat, product, accumulate, three multipliers, sum, clip
//  and queue write are registered in turn, then o_result.valid rises.
//  The x RAM needs no clearing pass; it is ready right after reset.
//  i_item.ready is low in reset and while the 8-entry output queue is fully
//  owed; i_cfg.ready is high outside reset.
// ----------------------------------------------------------------------------
`include "scaled_matrix_vector_multiply_add_defines.svh"

module scaled_matrix_vector_multiply_add import smvma_pkg::*; #(
    parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    smvma_cfg_if.sink       i_cfg,
    smvma_item_if.sink      i_item,
    smvma_result_if.source  o_result
);

    localparam int unsigned AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic signed [VAL_W-1:0] r_alpha;
    logic signed [VAL_W-1:0] r_beta;
    logic [COL_CNT_W-1:0]    r_col_count;
    logic [ROW_CNT_W-1:0]    r_row_count;

    logic                    w_cfg_acc;
    logic                    w_item_acc;
    logic                    w_is_mat;
    logic [31:0]             w_cols_eff;
    logic [31:0]             w_col32;
    logic                    w_last_col;
    logic                    w_x_we;
    logic                    w_mat_go;
    logic                    w_reserve;
    logic                    w_room;
    logic [VAL_W-1:0]        w_xdata;
    t_row_done               w_done;
    logic                    w_res_valid;
    t_result                 w_res;
    t_oq_status              w_oq_st;

    // Configuration
    assign i_cfg.ready = i_rst_n;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= GAIN_ONE;
            r_beta      <= GAIN_ONE;
            r_col_count <= COL_CNT_RESET;
            r_row_count <= ROW_CNT_RESET;
        end else if (w_cfg_acc) begin
            case (i_cfg.index)
                CFG_ALPHA: r_alpha     <= $signed(i_cfg.data);
                CFG_BETA:  r_beta      <= $signed(i_cfg.data);
                CFG_COLS:  r_col_count <= i_cfg.data[COL_CNT_W-1:0];
                CFG_ROWS:  r_row_count <= i_cfg.data[ROW_CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Item decode
    assign i_item.ready = i_rst_n && w_room;
    assign w_item_acc   = i_item.valid && i_item.ready;
    assign w_is_mat     = (t_opcode'(i_item.opcode) == OP_MATRIX);
    assign w_col32      = 32'(i_item.column_index);

    always_comb begin
        if (r_col_count == '0) begin
            w_cols_eff = 32'd1;
        end else if (32'(r_col_count) > 32'(MAX_COLUMNS)) begin
            w_cols_eff = 32'(MAX_COLUMNS);
        end else begin
            w_cols_eff = 32'(r_col_count);
        end
    end

    assign w_last_col = (w_col32 == (w_cols_eff - 32'd1));
    // drop x writes past the store and matrix beats past the active width
    assign w_x_we     = w_item_acc && !w_is_mat && (w_col32 < 32'(MAX_COLUMNS));
    assign w_mat_go   = w_item_acc && w_is_mat && (w_col32 < w_cols_eff);
    assign w_reserve  = w_mat_go && w_last_col;

    smvma_ram #(
        .WIDTH (VAL_W),
        .DEPTH (MAX_COLUMNS)
    ) u_x_ram (
        .i_clk   (i_clk),
        .i_we    (w_x_we),
        .i_waddr (AW'(i_item.column_index)),
        .i_wdata (i_item.element_value),
        .i_re    (w_mat_go),
        .i_raddr (AW'(i_item.column_index)),
        .o_rdata (w_xdata)
    );

    smvma_acc #(
        .MAX_ROWS (MAX_ROWS)
    ) u_acc (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mat_go    (w_mat_go),
        .i_last_col  (w_last_col),
        .i_elem      (i_item.element_value),
        .i_y         (i_item.y_value),
        .i_xdata     (w_xdata),
        .i_row_count (r_row_count),
        .o_done      (w_done)
    );

    smvma_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_done  (w_done),
        .i_alpha (r_alpha),
        .i_beta  (r_beta),
        .o_valid (w_res_valid),
        .o_res   (w_res)
    );

    smvma_oq u_oq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_reserve (w_reserve),
        .i_push    (w_res_valid),
        .i_data    (w_res),
        .o_room    (w_room),
        .o_status  (w_oq_st),
        .o_result  (o_result)
    );

    // Checks
    `SMVMA_ASSERT(a_owed_covers_queued, i_clk, i_rst_n,
        w_oq_st.count <= w_oq_st.pending, "queue holds more results than were reserved")
    `SMVMA_ASSERT(a_scale_latency, i_clk, i_rst_n, w_done.valid |-> ##3 w_res_valid,
        "finished row did not reach the clip stage in 3 cycles")
    `SMVMA_ASSERT_IMPL(a_push_has_slot, i_clk, i_rst_n, w_res_valid,
        w_oq_st.count < PEND_W'(OUT_DEPTH), "result pushed into a full output queue")

endmodule
